FILE: rtl/ilha_pkg.sv
// Shared types and constants for the boundary-tag heap allocator.
package ilha_pkg;

  // Width of internal byte-address arithmetic; holds tag sums and wrapped offsets.
  localparam int AW = 36;
  // Heap word and tag width.
  localparam int TW = 32;
  localparam int CHUNK_W = 17;
  localparam int DEF_HEAP_WORDS = 16384;
  localparam logic [CHUNK_W-1:0] DEF_GROW_CHUNK = 17'd4096;
  localparam logic [TW-1:0] TAG_MASK = 32'hFFFF_FFF8;

  // Operation codes
  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ZERO_SIZE = 2'd1;
  localparam logic [1:0] ST_NO_MEM    = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] request_bytes;
    logic [15:0] free_address;
  } ilha_in_t;

  typedef struct packed {
    logic [15:0] block_address;
    logic [1:0]  status;
  } ilha_out_t;

endpackage

FILE: rtl/implicit_list_heap_allocator_unit.sv
// Init, free and alloc each run as a sequence of tag reads and writes; ignored or rejected items
// go straight to the result, and alloc scans headers first-fit and grows the heap if none fits.
// Throughput: one item at a time; the single heap memory port and its shared address
// adder carry every tag access, so the rate is set by the number of tag reads and writes.
// Reset: synchronous, active low; clears the break to zero and the chunk size to 4096.
// Heap memory is not cleared; words are only read below the break.
module implicit_list_heap_allocator_unit
  import ilha_pkg::*;
#(
  parameter int HEAP_WORDS = DEF_HEAP_WORDS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ilha_in_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ilha_out_t          out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CHUNK_W-1:0] cfg_grow_chunk_bytes
);

  localparam int IW = $clog2(HEAP_WORDS);
  localparam int BW = IW + 3;
  localparam logic [AW-1:0] HEAP_BYTES = AW'(HEAP_WORDS) << 2;
  localparam logic [AW-1:0] NEG4 = ~AW'(3);
  localparam logic [AW-1:0] NEG8 = ~AW'(7);

  typedef enum logic [5:0] {
    S_IDLE, S_I0, S_I1, S_I2, S_I3,
    S_G0, S_G1, S_G2, S_G3,
    S_M0, S_M1, S_M2, S_M3, S_M4, S_M5,
    S_MA1, S_MA2, S_MA3, S_MB1, S_MB2, S_MC0, S_MC1, S_MC2, S_MC3,
    S_RET, S_F0, S_F1, S_FR0, S_FR1, S_FR2,
    S_P0, S_P1, S_PS1, S_PS2, S_PS3, S_PS4, S_PU1, S_PU2, S_PU3,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {CTX_INIT, CTX_ALLOC, CTX_FREE} ctx_t;

  state_t state_r, state_nxt;
  ctx_t ctx_r, ctx_nxt;
  logic [BW-1:0] brk_r, brk_nxt;
  logic [CHUNK_W-1:0] chunk_r, chunk_nxt;
  logic [16:0] asize_r, asize_nxt;
  logic [AW-1:0] gbytes_r, gbytes_nxt;
  logic [AW-1:0] bp_r, bp_nxt, prev_r, prev_nxt, next_r, next_nxt, acc_r, acc_nxt;
  logic [TW-1:0] sz_r, sz_nxt, t_r, t_nxt, nsz_r, nsz_nxt, old_r, old_nxt;
  logic [TW-1:0] save_r, save_nxt, rest_r, rest_nxt;
  logic pu_r, pu_nxt, first_r, first_nxt, rd_ok_r, rd_ok_nxt;
  logic out_valid_r, out_valid_nxt;
  ilha_out_t res_r, res_nxt, out_data_r, out_data_nxt;

  logic [TW-1:0] heap_mem_r [HEAP_WORDS];
  logic [TW-1:0] rd_data_r;

  // Shared address unit and memory request
  logic [AW-1:0] ea_base, ea_off, ea;
  logic in_rng, do_rd, do_wr;
  logic [TW-1:0] wdata;
  logic [IW-1:0] idx;

  logic [TW-1:0] rdat, m32;
  logic [AW-1:0] mz, rest_w, chunk_w, grow_end;
  logic [16:0] sum17, asize_w;
  logic [15:0] words_e;

  assign ea = ea_base + ea_off;
  assign in_rng = !ea[AW-1] && (ea < AW'(brk_r));
  assign idx = ea[IW+1:2];
  assign rdat = rd_ok_r ? rd_data_r : '0;
  assign m32 = rdat & TAG_MASK;
  assign mz = AW'(m32);

  // Request rounded to 8 bytes plus tags, minimum 16
  assign sum17 = {1'b0, in_data.request_bytes} + 17'd15;
  assign asize_w = (in_data.request_bytes <= 16'd8) ? 17'd16 : {sum17[16:3], 3'b000};

  // Chunk as an even word count, at least two words
  assign words_e = {1'b0, chunk_r[16:2]} + {15'b0, chunk_r[2]};
  assign chunk_w = (words_e[15:1] == '0) ? AW'(8) : AW'({words_e[15:1], 3'b000});

  assign rest_w = mz - AW'(asize_r);
  assign grow_end = AW'(brk_r) + gbytes_r;

  assign in_ready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    ctx_nxt = ctx_r;
    brk_nxt = brk_r;
    chunk_nxt = cfg_valid ? cfg_grow_chunk_bytes : chunk_r;
    asize_nxt = asize_r;
    gbytes_nxt = gbytes_r;
    bp_nxt = bp_r;
    prev_nxt = prev_r;
    next_nxt = next_r;
    acc_nxt = acc_r;
    sz_nxt = sz_r;
    t_nxt = t_r;
    nsz_nxt = nsz_r;
    old_nxt = old_r;
    save_nxt = save_r;
    rest_nxt = rest_r;
    pu_nxt = pu_r;
    first_nxt = first_r;
    res_nxt = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt = out_data_r;
    ea_base = bp_r;
    ea_off = NEG4;
    do_rd = 1'b0;
    do_wr = 1'b0;
    wdata = '0;
    rd_ok_nxt = in_rng;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_nxt = '{block_address: 16'd0, status: ST_OK};
          case (in_data.operation)
            OP_INIT: begin
              brk_nxt = BW'(16);
              state_nxt = S_I0;
            end
            OP_ALLOC: begin
              if (in_data.request_bytes == '0) begin
                res_nxt.status = ST_ZERO_SIZE;
                state_nxt = S_DONE;
              end else if (brk_r < BW'(16)) begin
                res_nxt.status = ST_NO_MEM;
                state_nxt = S_DONE;
              end else begin
                asize_nxt = asize_w;
                bp_nxt = AW'(8);
                first_nxt = 1'b1;
                state_nxt = S_F0;
              end
            end
            OP_FREE: begin
              if (brk_r >= BW'(16) && in_data.free_address[2:0] == 3'b000 &&
                  in_data.free_address >= 16'd16 &&
                  AW'(in_data.free_address) < AW'(brk_r)) begin
                bp_nxt = AW'(in_data.free_address);
                ctx_nxt = CTX_FREE;
                state_nxt = S_FR0;
              end else begin
                state_nxt = S_DONE;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      // Padding, prologue and epilogue
      S_I0: begin
        ea_base = '0; ea_off = AW'(0); do_wr = 1'b1; wdata = 32'd0;
        state_nxt = S_I1;
      end
      S_I1: begin
        ea_base = '0; ea_off = AW'(4); do_wr = 1'b1; wdata = 32'd9;
        state_nxt = S_I2;
      end
      S_I2: begin
        ea_base = '0; ea_off = AW'(8); do_wr = 1'b1; wdata = 32'd9;
        state_nxt = S_I3;
      end
      S_I3: begin
        ea_base = '0; ea_off = AW'(12); do_wr = 1'b1; wdata = 32'd1;
        gbytes_nxt = chunk_w;
        ctx_nxt = CTX_INIT;
        state_nxt = S_G0;
      end
      // Heap growth
      S_G0: begin
        if (grow_end > HEAP_BYTES) begin
          res_nxt.status = ST_NO_MEM;
          state_nxt = S_DONE;
        end else begin
          bp_nxt = AW'(brk_r);
          brk_nxt = grow_end[BW-1:0];
          state_nxt = S_G1;
        end
      end
      S_G1: begin
        do_wr = 1'b1; wdata = gbytes_r[TW-1:0];
        state_nxt = S_G2;
      end
      S_G2: begin
        ea_off = gbytes_r + NEG8; do_wr = 1'b1; wdata = gbytes_r[TW-1:0];
        state_nxt = S_G3;
      end
      S_G3: begin
        ea_off = gbytes_r + NEG4; do_wr = 1'b1; wdata = 32'd1;
        state_nxt = S_M0;
      end
      // Coalesce around bp
      S_M0: begin
        ea_off = NEG8; do_rd = 1'b1;
        state_nxt = S_M1;
      end
      S_M1: begin
        prev_nxt = bp_r - mz;
        do_rd = 1'b1;
        state_nxt = S_M2;
      end
      S_M2: begin
        sz_nxt = m32;
        next_nxt = bp_r + mz;
        ea_base = prev_r; do_rd = 1'b1;
        state_nxt = S_M3;
      end
      S_M3: begin
        t_nxt = m32;
        ea_base = prev_r; ea_off = mz + NEG8; do_rd = 1'b1;
        state_nxt = S_M4;
      end
      S_M4: begin
        pu_nxt = rdat[0];
        ea_base = next_r; do_rd = 1'b1;
        state_nxt = S_M5;
      end
      S_M5: begin
        if (pu_r && rdat[0]) begin
          state_nxt = S_RET;
        end else if (pu_r) begin
          acc_nxt = AW'(sz_r) + mz;
          state_nxt = S_MA1;
        end else if (rdat[0]) begin
          acc_nxt = AW'(sz_r) + AW'(t_r);
          state_nxt = S_MB1;
        end else begin
          acc_nxt = AW'(sz_r) + AW'(t_r);
          nsz_nxt = m32;
          state_nxt = S_MC0;
        end
      end
      S_MA1: begin
        do_wr = 1'b1; wdata = acc_r[TW-1:0];
        state_nxt = S_MA2;
      end
      S_MA2: begin
        do_rd = 1'b1;
        state_nxt = S_MA3;
      end
      S_MA3: begin
        ea_off = mz + NEG8; do_wr = 1'b1; wdata = acc_r[TW-1:0];
        state_nxt = S_RET;
      end
      S_MB1: begin
        ea_off = AW'(sz_r) + NEG8; do_wr = 1'b1; wdata = acc_r[TW-1:0];
        state_nxt = S_MB2;
      end
      S_MB2: begin
        ea_base = prev_r; do_wr = 1'b1; wdata = acc_r[TW-1:0];
        bp_nxt = prev_r;
        state_nxt = S_RET;
      end
      S_MC0: begin
        acc_nxt = acc_r + AW'(nsz_r);
        state_nxt = S_MC1;
      end
      S_MC1: begin
        ea_base = prev_r; do_wr = 1'b1; wdata = acc_r[TW-1:0];
        state_nxt = S_MC2;
      end
      S_MC2: begin
        ea_base = next_r; do_rd = 1'b1;
        state_nxt = S_MC3;
      end
      S_MC3: begin
        ea_base = next_r; ea_off = mz + NEG8; do_wr = 1'b1; wdata = acc_r[TW-1:0];
        bp_nxt = prev_r;
        state_nxt = S_RET;
      end
      S_RET: begin
        if (ctx_r == CTX_ALLOC) begin
          state_nxt = S_P0;
        end else begin
          state_nxt = S_DONE;
        end
      end
      // First-fit walk, one header per cycle
      S_F0: begin
        do_rd = 1'b1;
        state_nxt = S_F1;
      end
      S_F1: begin
        if (!first_r && !rdat[0] && m32 >= TW'(asize_r)) begin
          state_nxt = S_P0;
        end else if (m32 == '0) begin
          gbytes_nxt = (AW'(asize_r) > chunk_w) ? AW'(asize_r) : chunk_w;
          ctx_nxt = CTX_ALLOC;
          state_nxt = S_G0;
        end else begin
          bp_nxt = bp_r + mz;
          ea_off = mz + NEG4; do_rd = 1'b1;
          first_nxt = 1'b0;
        end
      end
      // Free: clear tags then coalesce
      S_FR0: begin
        do_rd = 1'b1;
        state_nxt = S_FR1;
      end
      S_FR1: begin
        sz_nxt = m32;
        do_wr = 1'b1; wdata = m32;
        state_nxt = S_FR2;
      end
      S_FR2: begin
        ea_off = AW'(sz_r) + NEG8; do_wr = 1'b1; wdata = sz_r;
        state_nxt = S_M0;
      end
      // Place, splitting when the remainder can hold a block
      S_P0: begin
        do_rd = 1'b1;
        state_nxt = S_P1;
      end
      S_P1: begin
        old_nxt = m32;
        save_nxt = rdat;
        rest_nxt = rest_w[TW-1:0];
        state_nxt = (rest_w >= AW'(16)) ? S_PS1 : S_PU1;
      end
      S_PS1: begin
        do_wr = 1'b1; wdata = TW'(asize_r) | 32'd1;
        state_nxt = S_PS2;
      end
      S_PS2: begin
        ea_off = AW'(asize_r) + NEG8; do_wr = 1'b1; wdata = TW'(asize_r) | 32'd1;
        state_nxt = S_PS3;
      end
      S_PS3: begin
        ea_off = AW'(asize_r) + NEG4; do_wr = 1'b1; wdata = rest_r;
        state_nxt = S_PS4;
      end
      S_PS4: begin
        ea_off = AW'(old_r) + NEG8; do_wr = 1'b1; wdata = rest_r;
        res_nxt.block_address = bp_r[15:0];
        state_nxt = S_DONE;
      end
      S_PU1: begin
        do_wr = 1'b1; wdata = save_r | 32'd1;
        state_nxt = S_PU2;
      end
      S_PU2: begin
        ea_off = AW'(old_r) + NEG8; do_rd = 1'b1;
        state_nxt = S_PU3;
      end
      S_PU3: begin
        ea_off = AW'(old_r) + NEG8; do_wr = 1'b1; wdata = rdat | 32'd1;
        res_nxt.block_address = bp_r[15:0];
        state_nxt = S_DONE;
      end
      // Hand the item to the output register
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt = res_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ctx_r <= CTX_INIT;
      brk_r <= '0;
      chunk_r <= DEF_GROW_CHUNK;
      out_valid_r <= 1'b0;
      rd_ok_r <= 1'b0;
      first_r <= 1'b0;
      pu_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ctx_r <= ctx_nxt;
      brk_r <= brk_nxt;
      chunk_r <= chunk_nxt;
      out_valid_r <= out_valid_nxt;
      rd_ok_r <= rd_ok_nxt;
      first_r <= first_nxt;
      pu_r <= pu_nxt;
    end
    asize_r <= asize_nxt;
    gbytes_r <= gbytes_nxt;
    bp_r <= bp_nxt;
    prev_r <= prev_nxt;
    next_r <= next_nxt;
    acc_r <= acc_nxt;
    sz_r <= sz_nxt;
    t_r <= t_nxt;
    nsz_r <= nsz_nxt;
    old_r <= old_nxt;
    save_r <= save_nxt;
    rest_r <= rest_nxt;
    res_r <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // Heap memory: one access per cycle, only below the break
  always_ff @(posedge clk) begin
    if (do_wr && in_rng) begin
      heap_mem_r[idx] <= wdata;
    end
    if (do_rd && in_rng) begin
      rd_data_r <= heap_mem_r[idx];
    end
  end

endmodule

FILE: rtl/ilha_checker.sv
// Port-level checks for the heap allocator, bound to the top level.
module ilha_checker
  import ilha_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input ilha_in_t           in_data,
  input logic               out_valid,
  input logic               out_ready,
  input ilha_out_t          out_data,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [CHUNK_W-1:0] cfg_grow_chunk_bytes
);

  // An accepted item keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after accept");

  // Only a successful allocate carries an address
  a_addr_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.block_address == 16'd0)
    else $error("address given with error status");

  // Payload addresses are 8-byte aligned
  a_addr_align: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.block_address[2:0] == 3'b000)
    else $error("unaligned block address");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

endmodule

bind implicit_list_heap_allocator_unit ilha_checker u_ilha_checker (.*);

FILE: bench/tb_implicit_list_heap_allocator_unit.sv
// Self-checking bench for the first-fit boundary-tag heap allocator unit.
`timescale 1ns / 1ps

module tb_implicit_list_heap_allocator_unit
  import ilha_pkg::*;
();

  typedef longint unsigned u64_t;
  localparam int   WORDS      = DEF_HEAP_WORDS;
  localparam u64_t HEAP_LIMIT = u64_t'(WORDS) * 4;
  localparam int   IDLE_LIMIT = 100000;
  // Operation code the block ignores
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  ilha_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ilha_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CHUNK_W-1:0] cfg_grow_chunk_bytes = '0;

  implicit_list_heap_allocator_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_grow_chunk_bytes(cfg_grow_chunk_bytes)
  );

  always #5 clk = ~clk;

  // Shadow heap and allocator state
  logic [31:0] heap_words [WORDS];
  bit          word_written [WORDS];
  logic [31:0] saved_words [WORDS];
  bit          saved_written [WORDS];
  u64_t brk_off = 0;
  u64_t base_addr = 8;
  logic [CHUNK_W-1:0] chunk_cfg = DEF_GROW_CHUNK;
  bit   stale_read;

  ilha_in_t  item_q [$];
  ilha_out_t alloc_result_q [$];
  u64_t live_blocks [$];
  u64_t freed_blocks [$];
  int   errs = 0;

  // Growth chunk values swept by the phases
  logic [CHUNK_W-1:0] chunk_sweep [10] = '{17'd8, 17'd0, 17'd12, 17'd4, 17'd65536,
                                           17'd131071, 17'd60000, 17'd1000, 17'd24,
                                           17'd4096};

  function automatic logic [31:0] hp_rd(u64_t a);
    if (a >= brk_off) return '0;
    if (!word_written[a >> 2]) stale_read = 1'b1;
    return heap_words[a >> 2];
  endfunction

  function automatic void hp_wr(u64_t a, logic [31:0] v);
    if (a >= brk_off) return;
    heap_words[a >> 2] = v;
    word_written[a >> 2] = 1'b1;
  endfunction

  function automatic u64_t blk_bytes(u64_t bp);
    return u64_t'(hp_rd(bp - 4) & TAG_MASK);
  endfunction

  function automatic u64_t coalesce(u64_t bp);
    u64_t prv, nxt, sz;
    bit   prv_used, nxt_used;
    prv = bp - u64_t'(hp_rd(bp - 8) & TAG_MASK);
    nxt = bp + blk_bytes(bp);
    prv_used = (hp_rd(prv + blk_bytes(prv) - 8) & 32'd1) != 0;
    nxt_used = (hp_rd(nxt - 4) & 32'd1) != 0;
    sz = blk_bytes(bp);
    if (prv_used && nxt_used) return bp;
    if (prv_used) begin
      sz += blk_bytes(nxt);
      hp_wr(bp - 4, sz[31:0]);
      hp_wr(bp + blk_bytes(bp) - 8, sz[31:0]);
      return bp;
    end
    if (nxt_used) begin
      sz += blk_bytes(prv);
      hp_wr(bp + blk_bytes(bp) - 8, sz[31:0]);
      hp_wr(prv - 4, sz[31:0]);
      return prv;
    end
    sz += blk_bytes(prv) + blk_bytes(nxt);
    hp_wr(prv - 4, sz[31:0]);
    hp_wr(nxt + blk_bytes(nxt) - 8, sz[31:0]);
    return prv;
  endfunction

  function automatic bit grow_heap(u64_t bytes, output u64_t bp);
    u64_t b0;
    b0 = brk_off;
    bp = 0;
    if (bytes > HEAP_LIMIT || b0 > HEAP_LIMIT - bytes) return 1'b0;
    brk_off = b0 + bytes;
    hp_wr(b0 - 4, bytes[31:0]);
    hp_wr(b0 + bytes - 8, bytes[31:0]);
    hp_wr(b0 + bytes - 4, 32'd1);
    bp = coalesce(b0);
    return 1'b1;
  endfunction

  // Chunk in whole words, rounded up to an even count, never below two words
  function automatic u64_t chunk_len();
    u64_t w;
    w = u64_t'(chunk_cfg) >> 2;
    if (w[0]) w++;
    if (w == 0) w = 2;
    return w * 4;
  endfunction

  function automatic bit first_fit_scan(u64_t asize, output u64_t bp);
    bp = base_addr;
    while (blk_bytes(bp) != 0) begin
      bp += blk_bytes(bp);
      if ((hp_rd(bp - 4) & 32'd1) == 0 && blk_bytes(bp) >= asize) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void place_block(u64_t bp, u64_t asize);
    u64_t old, rest;
    old = blk_bytes(bp);
    rest = old - asize;
    if (rest >= 16) begin
      hp_wr(bp - 4, asize[31:0] | 32'd1);
      hp_wr(bp + asize - 8, asize[31:0] | 32'd1);
      hp_wr(bp + asize - 4, rest[31:0]);
      hp_wr(bp + old - 8, rest[31:0]);
    end else begin
      hp_wr(bp - 4, hp_rd(bp - 4) | 32'd1);
      hp_wr(bp + old - 8, hp_rd(bp + old - 8) | 32'd1);
    end
  endfunction

  // Applies one item to the shadow heap and returns the expected result
  function automatic ilha_out_t heap_op(ilha_in_t it);
    ilha_out_t r;
    u64_t bp, asize, ext, req, fa, sz;
    r = '0;
    req = u64_t'(it.request_bytes);
    fa = u64_t'(it.free_address);
    case (it.operation)
      OP_INIT: begin
        brk_off = 0;
        if (!grow_heap(0, bp)) begin
          r.status = ST_NO_MEM;
        end else begin
          brk_off = 16;
          hp_wr(0, 32'd0);
          hp_wr(4, 32'd9);
          hp_wr(8, 32'd9);
          hp_wr(12, 32'd1);
          base_addr = 8;
          if (!grow_heap(chunk_len(), bp)) r.status = ST_NO_MEM;
        end
      end
      OP_ALLOC: begin
        if (req == 0) begin
          r.status = ST_ZERO_SIZE;
        end else if (brk_off < 16) begin
          r.status = ST_NO_MEM;
        end else begin
          asize = (req <= 8) ? 16 : 8 * ((req + 15) / 8);
          if (first_fit_scan(asize, bp)) begin
            place_block(bp, asize);
            r.block_address = bp[15:0];
          end else begin
            ext = chunk_len();
            if (asize > ext) ext = asize;
            if (grow_heap(ext, bp)) begin
              place_block(bp, asize);
              r.block_address = bp[15:0];
            end else begin
              r.status = ST_NO_MEM;
            end
          end
        end
      end
      OP_FREE: begin
        if (brk_off >= 16 && fa[2:0] == 0 && fa >= 16 && fa < brk_off) begin
          sz = blk_bytes(fa);
          hp_wr(fa - 4, sz[31:0]);
          hp_wr(fa + sz - 8, sz[31:0]);
          void'(coalesce(fa));
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Predicts one item and queues it; an item that would touch never-written
  // words is swapped for one that the block ignores
  task automatic issue(logic [1:0] op, logic [15:0] req, logic [15:0] fa);
    ilha_in_t  it;
    ilha_out_t r;
    u64_t      saved_brk;
    it = '{operation: op, request_bytes: req, free_address: fa};
    saved_words = heap_words;
    saved_written = word_written;
    saved_brk = brk_off;
    stale_read = 1'b0;
    r = heap_op(it);
    if (stale_read) begin
      heap_words = saved_words;
      word_written = saved_written;
      brk_off = saved_brk;
      if (op == OP_FREE) it.free_address = fa | 16'h3;
      else it.operation = OP_UNUSED;
      r = heap_op(it);
    end
    if (it.operation == OP_INIT) live_blocks.delete();
    if (it.operation == OP_ALLOC && r.status == ST_OK)
      live_blocks.push_back(u64_t'(r.block_address));
    item_q.push_back(it);
    alloc_result_q.push_back(r);
  endtask

  task automatic free_live(int idx);
    u64_t a;
    a = live_blocks[idx];
    live_blocks.delete(idx);
    freed_blocks.push_back(a);
    if (freed_blocks.size() > 64) void'(freed_blocks.pop_front());
    issue(OP_FREE, 16'($urandom), a[15:0]);
  endtask

  task automatic drain();
    while (item_q.size() != 0 || in_valid || alloc_result_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_chunk(logic [CHUNK_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_grow_chunk_bytes <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    chunk_cfg = v;
  endtask

  // Receiver stall pattern, reshaped per phase
  logic [15:0] ready_pattern = 16'hFFFF;
  int unsigned cyc = 0;

  task automatic random_phase(int n);
    int r, z;
    logic [15:0] req, fa;
    @(negedge clk);
    ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h1);
    issue(OP_INIT, 16'($urandom), 16'($urandom));
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (live_blocks.size() > 200 && r < 50) r = 99;
      if (r < 2) begin
        issue(OP_INIT, 16'($urandom), 16'($urandom));
      end else if (r < 5) begin
        issue(OP_UNUSED, 16'($urandom), 16'($urandom));
      end else if (r < 58) begin
        z = $urandom_range(0, 99);
        if (z < 3) req = 16'd0;
        else if (z < 80) req = 16'($urandom_range(1, 64));
        else if (z < 95) req = 16'($urandom_range(65, 2048));
        else req = 16'($urandom);
        issue(OP_ALLOC, req, 16'($urandom));
      end else if (live_blocks.size() != 0 && $urandom_range(0, 99) < 85) begin
        free_live($urandom_range(0, live_blocks.size() - 1));
      end else begin
        z = $urandom_range(0, 2);
        if (z == 0 || freed_blocks.size() == 0) fa = 16'($urandom);
        else if (z == 1) fa = 16'($urandom_range(0, 8191)) << 3;
        else fa = freed_blocks[$urandom_range(0, freed_blocks.size() - 1)][15:0];
        issue(OP_FREE, 16'($urandom), fa);
      end
    end
  endtask

  // Stimulus and phase control
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // Directed: operations before init, tag edge cases, merges, growth
    issue(OP_ALLOC, 16'd5, 16'd0);
    issue(OP_FREE, 16'd0, 16'd16);
    issue(OP_UNUSED, 16'hFFFF, 16'hFFFF);
    issue(OP_INIT, 16'd0, 16'd0);
    issue(OP_ALLOC, 16'd0, 16'd0);
    issue(OP_ALLOC, 16'd1, 16'd0);
    issue(OP_ALLOC, 16'd8, 16'd0);
    issue(OP_ALLOC, 16'd9, 16'd0);
    issue(OP_ALLOC, 16'd24, 16'd0);
    issue(OP_ALLOC, 16'd4000, 16'd0);
    issue(OP_ALLOC, 16'hFFFF, 16'd0);
    issue(OP_ALLOC, 16'd5000, 16'd0);
    free_live(1);
    free_live(2);
    free_live(0);
    issue(OP_FREE, 16'd0, 16'd21);
    issue(OP_FREE, 16'd0, 16'd8);
    issue(OP_FREE, 16'd0, 16'hFFF8);
    issue(OP_ALLOC, 16'd40, 16'd0);
    issue(OP_ALLOC, 16'd3, 16'd0);
    issue(OP_INIT, 16'hFFFF, 16'hFFFF);
    issue(OP_ALLOC, 16'd100, 16'd0);
    drain();
    // Sweep the growth chunk through its extremes and odd word counts
    foreach (chunk_sweep[k]) begin
      write_chunk(chunk_sweep[k]);
      random_phase(175);
      drain();
    end
    if (errs == 0 && alloc_result_q.size() == 0) begin
      $display("implicit_list_heap_allocator_unit regression: pass");
    end else begin
      $display("implicit_list_heap_allocator_unit regression: fail");
    end
    $finish;
  end

  // Driver: bursts of items separated by random gaps
  int burst_left = 1;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) void'(item_q.pop_front());
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (item_q.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= item_q[0];
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result against the oldest prediction
  always @(posedge clk) begin
    ilha_out_t e;
    cyc++;
    out_ready <= ready_pattern[cyc % 16];
    if (rst_n && out_valid && out_ready) begin
      if (alloc_result_q.size() == 0) begin
        $error("unexpected result %p", out_data);
        errs++;
      end else begin
        e = alloc_result_q.pop_front();
        if (out_data.block_address !== e.block_address) begin
          $error("block_address expected %0d got %0d", e.block_address,
                 out_data.block_address);
          errs++;
        end
        if (out_data.status !== e.status) begin
          $error("status expected %0d got %0d", e.status, out_data.status);
          errs++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake on the input, output or config port
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("implicit_list_heap_allocator_unit regression: fail");
      $finish;
    end
  end

endmodule
